FILE: hdl/dccv_pkg.sv
// Shared types, constants and calendar tables for the date / day count converter.
package dccv_pkg;

  localparam int unsigned NSTAGE = 6;

  typedef logic [NSTAGE-1:0] stage_vec_t;

  typedef enum logic {
    CMD_TO_COUNT = 1'b0,
    CMD_TO_DATE  = 1'b1
  } cmd_e;

  localparam logic [11:0] EPOCH_YEAR      = 12'd1970;
  localparam logic [11:0] LAST_YEAR       = 12'd2149;
  localparam logic [11:0] CENT_YEAR       = 12'd2100;
  localparam logic [11:0] MARCH_BASE_YEAR = 12'd1968;
  localparam logic [16:0] YEAR_DAYS       = 17'd365;
  // day 0 sits 671 days after 1968-03-01
  localparam logic [16:0] EPOCH_OFFSET    = 17'd671;
  // first day count on or after 2100-03-01
  localparam logic [15:0] SKIP_COUNT      = 16'd47541;
  localparam logic [16:0] CYC_DAYS        = 17'd1461;
  localparam logic [16:0] CYC_RECIP       = 17'd91868;
  localparam int unsigned CYC_SHIFT       = 27;
  localparam logic [11:0] WEEK_RECIP      = 12'd2341;
  localparam int unsigned WEEK_SHIFT      = 14;

  // days before the month, common year
  function automatic logic [8:0] days_before(input logic [3:0] m);
    case (m)
      4'd1:    return 9'd0;
      4'd2:    return 9'd31;
      4'd3:    return 9'd59;
      4'd4:    return 9'd90;
      4'd5:    return 9'd120;
      4'd6:    return 9'd151;
      4'd7:    return 9'd181;
      4'd8:    return 9'd212;
      4'd9:    return 9'd243;
      4'd10:   return 9'd273;
      4'd11:   return 9'd304;
      4'd12:   return 9'd334;
      default: return 9'd0;
    endcase
  endfunction

  // month length, common year; zero for a month that does not exist
  function automatic logic [4:0] month_len(input logic [3:0] m);
    case (m)
      4'd1:    return 5'd31;
      4'd2:    return 5'd28;
      4'd3:    return 5'd31;
      4'd4:    return 5'd30;
      4'd5:    return 5'd31;
      4'd6:    return 5'd30;
      4'd7:    return 5'd31;
      4'd8:    return 5'd31;
      4'd9:    return 5'd30;
      4'd10:   return 5'd31;
      4'd11:   return 5'd30;
      4'd12:   return 5'd31;
      default: return 5'd0;
    endcase
  endfunction

  // first day of each month in a year that starts on March 1
  function automatic logic [8:0] march_start(input logic [3:0] k);
    case (k)
      4'd0:    return 9'd0;
      4'd1:    return 9'd31;
      4'd2:    return 9'd61;
      4'd3:    return 9'd92;
      4'd4:    return 9'd122;
      4'd5:    return 9'd153;
      4'd6:    return 9'd184;
      4'd7:    return 9'd214;
      4'd8:    return 9'd245;
      4'd9:    return 9'd275;
      4'd10:   return 9'd306;
      4'd11:   return 9'd337;
      default: return 9'd0;
    endcase
  endfunction

endpackage

FILE: hdl/date_day_count_converter.sv
// Six-stage pipeline that converts dates to day counts since 1970-01-01 and back.
// One word enters per clock while in_stall is low; the stage count is set by
// the stage chain of the day-count-to-date path (cycle divide, remainder, year in cycle,
// month search, week divide), which the date-to-count path matches with delay stages.
// A stall at the output holds only the stages that are full, so bubbles close up and the
// input keeps taking words while a finished result waits, until every stage is full.
module date_day_count_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [11:0] in_year,
  input  logic [3:0]  in_month,
  input  logic [4:0]  in_day,
  input  logic [15:0] in_day_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        valid_res,
  output logic [15:0] out_day_count,
  output logic [11:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day,
  output logic [8:0]  year_day,
  output logic [5:0]  year_week
);
  import dccv_pkg::*;

  stage_vec_t vld;
  stage_vec_t rdy;
  cmd_e       cmd_q [NSTAGE];
  cmd_e       out_cmd;

  logic        cnt_ok;
  logic [15:0] cnt;
  logic [11:0] d_year;
  logic [3:0]  d_month;
  logic [4:0]  d_day;
  logic [8:0]  d_yday;
  logic [5:0]  d_week;

  // a stage loads when it is empty or its successor loads
  always_comb begin
    rdy[NSTAGE-1] = !vld[NSTAGE-1] || !out_stall;
    for (int i = NSTAGE - 2; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  assign in_stall = !rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < NSTAGE; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      cmd_q[0] <= cmd_e'(cmd);
    end
    for (int i = 1; i < NSTAGE; i++) begin
      if (rdy[i]) begin
        cmd_q[i] <= cmd_q[i-1];
      end
    end
  end

  dccv_to_count u_to_count (
    .clk   (clk),
    .adv   (rdy),
    .year  (in_year),
    .month (in_month),
    .day   (in_day),
    .ok    (cnt_ok),
    .count (cnt)
  );

  dccv_to_date u_to_date (
    .clk       (clk),
    .adv       (rdy),
    .day_count (in_day_count),
    .year      (d_year),
    .month     (d_month),
    .day       (d_day),
    .yday      (d_yday),
    .yweek     (d_week)
  );

  assign out_cmd   = cmd_q[NSTAGE-1];
  assign out_valid = vld[NSTAGE-1];

  // fields of the other command read as zero
  always_comb begin
    if (out_cmd == CMD_TO_DATE) begin
      valid_res     = 1'b1;
      out_day_count = 16'd0;
      out_year      = d_year;
      out_month     = d_month;
      out_day       = d_day;
      year_day      = d_yday;
      year_week     = d_week;
    end else begin
      valid_res     = cnt_ok;
      out_day_count = cnt;
      out_year      = 12'd0;
      out_month     = 4'd0;
      out_day       = 5'd0;
      year_day      = 9'd0;
      year_week     = 6'd0;
    end
  end

  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_date_valid: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_cmd == CMD_TO_DATE)) |-> valid_res)
    else $error("count to date word marked invalid");

  a_date_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_cmd == CMD_TO_DATE)) |->
    ((out_month >= 4'd1) && (out_month <= 4'd12) && (out_day != 5'd0) &&
     (year_day != 9'd0) && (year_day <= 9'd366)))
    else $error("decoded date out of range");

  a_week: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_cmd == CMD_TO_DATE)) |->
    ((10'(year_week) * 10'd7 >= 10'(year_day)) &&
     (10'(year_week) * 10'd7 < 10'(year_day) + 10'd7)))
    else $error("week of year does not match day of year");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !valid_res) |-> (out_day_count == 16'd0))
    else $error("invalid word carries a day count");

endmodule

FILE: hdl/dccv_to_count.sv
// Date to day count datapath: check the date, then sum years, leap days and day of year.
module dccv_to_count (
  input  logic                clk,
  input  dccv_pkg::stage_vec_t adv,
  input  logic [11:0]         year,
  input  logic [3:0]          month,
  input  logic [4:0]          day,
  output logic                ok,
  output logic [15:0]         count
);
  import dccv_pkg::*;

  logic       leap;
  logic [4:0] mlen;
  logic       date_ok;

  logic       s0_ok;
  logic [7:0] s0_yoff;
  logic [5:0] s0_nleap;
  logic [8:0] s0_bmon;
  logic [4:0] s0_day;

  logic        s1_ok;
  logic [16:0] s1_prod;
  logic [5:0]  s1_nleap;
  logic [8:0]  s1_bmon;
  logic [4:0]  s1_day;

  logic [16:0] total;

  logic        ok_q  [2:NSTAGE-1];
  logic [15:0] cnt_q [2:NSTAGE-1];

  // in range only 2100 breaks the divide-by-four rule
  assign leap    = (year[1:0] == 2'd0) && (year != CENT_YEAR);
  assign mlen    = month_len(month) + 5'((month == 4'd2) && leap);
  assign date_ok = (year >= EPOCH_YEAR) && (year <= LAST_YEAR) &&
                   (month >= 4'd1) && (month <= 4'd12) &&
                   (day != 5'd0) && (day <= mlen);

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s0_ok    <= date_ok;
      s0_yoff  <= 8'(year - EPOCH_YEAR);
      s0_nleap <= 6'((9'(8'(year - EPOCH_YEAR)) + 9'd1) >> 2) - 6'(year > CENT_YEAR);
      s0_bmon  <= days_before(month) + 9'((month > 4'd2) && leap);
      s0_day   <= day;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_ok    <= s0_ok;
      s1_prod  <= 17'(s0_yoff) * YEAR_DAYS;
      s1_nleap <= s0_nleap;
      s1_bmon  <= s0_bmon;
      s1_day   <= s0_day;
    end
  end

  assign total = s1_prod + 17'(s1_nleap) + 17'(s1_bmon) + 17'(s1_day) - 17'd1;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      ok_q[2]  <= s1_ok && !total[16];
      cnt_q[2] <= (s1_ok && !total[16]) ? total[15:0] : 16'd0;
    end
    for (int i = 3; i < NSTAGE; i++) begin
      if (adv[i]) begin
        ok_q[i]  <= ok_q[i-1];
        cnt_q[i] <= cnt_q[i-1];
      end
    end
  end

  assign ok    = ok_q[NSTAGE-1];
  assign count = cnt_q[NSTAGE-1];

endmodule

FILE: hdl/dccv_to_date.sv
// Day count to date datapath: four-year cycles from 1968-03-01, then year, month, week.
module dccv_to_date (
  input  logic                clk,
  input  dccv_pkg::stage_vec_t adv,
  input  logic [15:0]         day_count,
  output logic [11:0]         year,
  output logic [3:0]          month,
  output logic [4:0]          day,
  output logic [8:0]          yday,
  output logic [5:0]          yweek
);
  import dccv_pkg::*;

  localparam logic [8:0] JAN1_DOY  = 9'd305;
  localparam logic [8:0] MAR1_YDAY = 9'd60;

  logic [16:0] s0_z;

  logic [33:0] cyc_prod;
  logic [16:0] s1_z;
  logic [5:0]  s1_cyc;

  logic [10:0] s2_r;
  logic [5:0]  s2_cyc;

  logic [1:0]  yic;
  logic [8:0]  s3_doy;
  logic [11:0] s3_ymar;

  logic [3:0]  mp;
  logic        jan_feb;
  logic        leap;
  logic [11:0] s4_year;
  logic [3:0]  s4_month;
  logic [4:0]  s4_day;
  logic [8:0]  s4_yd;

  logic [20:0] week_prod;
  logic [11:0] s5_year;
  logic [3:0]  s5_month;
  logic [4:0]  s5_day;
  logic [8:0]  s5_yd;
  logic [5:0]  s5_week;

  // days from 2100-03-01 on move up one, skipping the Feb 29 that 2100 lacks
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s0_z <= 17'(day_count) + EPOCH_OFFSET + 17'(day_count >= SKIP_COUNT);
    end
  end

  assign cyc_prod = 34'(s0_z) * 34'(CYC_RECIP);

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_z   <= s0_z;
      s1_cyc <= cyc_prod[CYC_SHIFT +: 6];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s2_r   <= 11'(s1_z - 17'(s1_cyc) * CYC_DAYS);
      s2_cyc <= s1_cyc;
    end
  end

  assign yic = 2'(s2_r >= 11'd365) + 2'(s2_r >= 11'd730) + 2'(s2_r >= 11'd1095);

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s3_doy  <= 9'(s2_r - 11'(yic) * 11'd365);
      s3_ymar <= MARCH_BASE_YEAR + 12'({s2_cyc, yic});
    end
  end

  always_comb begin
    mp = 4'd0;
    for (int k = 1; k < 12; k++) begin
      mp = mp + 4'(s3_doy >= march_start(4'(k)));
    end
  end

  assign jan_feb = (mp >= 4'd10);
  assign leap    = (s3_ymar[1:0] == 2'd0) && (s3_ymar != CENT_YEAR);

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s4_year  <= s3_ymar + 12'(jan_feb);
      s4_month <= jan_feb ? (mp - 4'd9) : (mp + 4'd3);
      s4_day   <= 5'(s3_doy - march_start(mp) + 9'd1);
      s4_yd    <= jan_feb ? (s3_doy - JAN1_DOY) : (s3_doy + MAR1_YDAY + 9'(leap));
    end
  end

  // ceil(yd / 7) as floor((yd + 6) / 7) by reciprocal
  assign week_prod = 21'(s4_yd + 9'd6) * 21'(WEEK_RECIP);

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s5_year  <= s4_year;
      s5_month <= s4_month;
      s5_day   <= s4_day;
      s5_yd    <= s4_yd;
      s5_week  <= week_prod[WEEK_SHIFT +: 6];
    end
  end

  assign year  = s5_year;
  assign month = s5_month;
  assign day   = s5_day;
  assign yday  = s5_yd;
  assign yweek = s5_week;

endmodule
